// ===== rtl/kstt_pkg.sv =====
// ----------------------------------------------------------------------------
// kstt_pkg
// Shared types and codes of the keyed software timer table: the request and
// response items and the command, status and result kind codes.
// ----------------------------------------------------------------------------
package kstt_pkg;

   // command codes
   localparam logic [1:0] CMD_SET    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   // one request item
   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  task_id;
      logic [7:0]  signal;
      logic [31:0] period;
      logic        periodic;
      logic [15:0] elapsed;
   } req_type;

   // one response item
   typedef struct packed {
      logic       kind;
      logic [1:0] status;
      logic [7:0] expired_task;
      logic [7:0] expired_signal;
      logic       last;
   } rsp_type;

endpackage

// ===== rtl/kstt_ram.sv =====
// ----------------------------------------------------------------------------
// kstt_ram
// Generic simple dual port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module kstt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/keyed_software_timer_table.sv =====
// ----------------------------------------------------------------------------
// keyed_software_timer_table
// Table of TIMERS one-shot or periodic timers keyed by (task, signal).
//
// An item is taken on a rising edge with start high and busy low. A set item
// updates a matching timer or claims the lowest free slot; a remove item frees
// the matching slot; a tick item lowers every running count by elapsed and
// reports each timer that reaches zero, in slot order.
// Results come out on rsp_data, each for one cycle with rsp_strobe high; the
// receiver cannot hold them off. Every item ends in one result with last set.
// Set, remove and tick scan the slot RAM one slot per cycle, while busy stays
// high; the final result comes out in the cycle that busy falls, and the
// scan through the single read port of the slot RAM sets the rate.
// Expiry results of a tick but the last come out during the scan, at most one a cycle.
// An unused command code is answered in the cycle after it is taken, with
// busy staying low.
// Reset clears the valid bits of all slots and returns the block to idle;
// slot contents are only read for valid slots and need no clearing.
// ----------------------------------------------------------------------------
module keyed_software_timer_table
   import kstt_pkg::*;
#(
   parameter int TIMERS      = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IDX_WIDTH = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam logic [IDX_WIDTH-1:0] LAST_SLOT = IDX_WIDTH'(TIMERS - 1);
   localparam int CMP_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   typedef struct packed {
      logic [7:0]             task_id;
      logic [7:0]             signal;
      logic                   periodic;
      logic [COUNT_WIDTH-1:0] period;
      logic [COUNT_WIDTH-1:0] remaining;
   } slot_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [TIMERS-1:0]     valid_ff, valid_in;
   logic [IDX_WIDTH-1:0]  scan_idx_ff, scan_idx_in;
   logic                  issue_on_ff, issue_on_in;
   logic                  proc_valid_ff, proc_valid_in;
   logic [IDX_WIDTH-1:0]  proc_idx_ff, proc_idx_in;
   logic                  found_ff, found_in;
   logic [IDX_WIDTH-1:0]  match_idx_ff, match_idx_in;
   logic                  match_periodic_ff, match_periodic_in;
   logic                  free_found_ff, free_found_in;
   logic [IDX_WIDTH-1:0]  free_idx_ff, free_idx_in;
   logic                  pend_ff, pend_in;
   logic [7:0]            pend_task_ff, pend_task_in;
   logic [7:0]            pend_signal_ff, pend_signal_in;
   req_type               req_ff, req_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  ram_wr_en;
   logic [IDX_WIDTH-1:0]  ram_wr_addr;
   slot_type              ram_wr_data;
   logic                  ram_rd_en;
   slot_type              rd_slot;

   logic [COUNT_WIDTH-1:0] period_sat;
   logic [CMP_WIDTH-1:0]   rem_wide;
   logic [CMP_WIDTH-1:0]   elapsed_wide;
   logic [COUNT_WIDTH-1:0] rem_next;
   logic                   expired;

   // slot contents
   kstt_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (TIMERS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_slot)
   );

   // period clipped to the count width
   if (COUNT_WIDTH < 32) begin : g_sat
      assign period_sat = (|req_ff.period[31:COUNT_WIDTH]) ? '1
                                                           : req_ff.period[COUNT_WIDTH-1:0];
   end else begin : g_ext
      assign period_sat = COUNT_WIDTH'(req_ff.period);
   end

   // count after a tick, stopping at zero
   assign rem_wide     = CMP_WIDTH'(rd_slot.remaining);
   assign elapsed_wide = CMP_WIDTH'(req_ff.elapsed);
   assign rem_next     = (elapsed_wide < rem_wide) ? COUNT_WIDTH'(rem_wide - elapsed_wide)
                                                   : '0;
   assign expired      = (rem_next == '0);

   // sequencer: scan, read-modify-write, results
   always_comb begin
      state_in          = state_ff;
      valid_in          = valid_ff;
      scan_idx_in       = scan_idx_ff;
      issue_on_in       = issue_on_ff;
      proc_valid_in     = 1'b0;
      proc_idx_in       = scan_idx_ff;
      found_in          = found_ff;
      match_idx_in      = match_idx_ff;
      match_periodic_in = match_periodic_ff;
      free_found_in     = free_found_ff;
      free_idx_in       = free_idx_ff;
      pend_in           = pend_ff;
      pend_task_in      = pend_task_ff;
      pend_signal_in    = pend_signal_ff;
      req_in            = req_ff;
      rsp_strobe_in     = 1'b0;
      rsp_in            = '0;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = proc_idx_ff;
      ram_wr_data       = rd_slot;
      ram_rd_en         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.command inside {CMD_SET, CMD_REMOVE, CMD_TICK}) begin
                  state_in      = ST_SCAN;
                  scan_idx_in   = '0;
                  issue_on_in   = 1'b1;
                  found_in      = 1'b0;
                  free_found_in = 1'b0;
                  pend_in       = 1'b0;
               end else begin
                  // unused code: plain acknowledge
                  rsp_strobe_in = 1'b1;
                  rsp_in.last   = 1'b1;
               end
            end
         end

         ST_SCAN: begin
            // read side of the scan
            if (issue_on_ff) begin
               ram_rd_en     = 1'b1;
               proc_valid_in = 1'b1;
               proc_idx_in   = scan_idx_ff;
               if (scan_idx_ff == LAST_SLOT) begin
                  issue_on_in = 1'b0;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_WIDTH'(1);
               end
            end
            // process the slot read in the previous cycle
            if (proc_valid_ff) begin
               if (req_ff.command == CMD_TICK) begin
                  if (valid_ff[proc_idx_ff]) begin
                     ram_wr_en             = 1'b1;
                     ram_wr_data.remaining = rem_next;
                     if (expired) begin
                        if (rd_slot.periodic) begin
                           ram_wr_data.remaining = rd_slot.period;
                        end else begin
                           valid_in[proc_idx_ff] = 1'b0;
                        end
                        // hold back one expiry so the final one can carry last
                        if (pend_ff) begin
                           rsp_strobe_in         = 1'b1;
                           rsp_in.kind           = KIND_EXPIRY;
                           rsp_in.expired_task   = pend_task_ff;
                           rsp_in.expired_signal = pend_signal_ff;
                        end
                        pend_in        = 1'b1;
                        pend_task_in   = rd_slot.task_id;
                        pend_signal_in = rd_slot.signal;
                     end
                  end
               end else begin
                  if (valid_ff[proc_idx_ff] && !found_ff &&
                      rd_slot.task_id == req_ff.task_id &&
                      rd_slot.signal == req_ff.signal) begin
                     found_in          = 1'b1;
                     match_idx_in      = proc_idx_ff;
                     match_periodic_in = rd_slot.periodic;
                  end
                  if (!valid_ff[proc_idx_ff] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = proc_idx_ff;
                  end
               end
               if (proc_idx_ff == LAST_SLOT) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_in.last   = 1'b1;
            ram_wr_data.task_id   = req_ff.task_id;
            ram_wr_data.signal    = req_ff.signal;
            ram_wr_data.period    = period_sat;
            ram_wr_data.remaining = period_sat;
            case (req_ff.command)
               CMD_TICK: begin
                  if (pend_ff) begin
                     rsp_in.kind           = KIND_EXPIRY;
                     rsp_in.expired_task   = pend_task_ff;
                     rsp_in.expired_signal = pend_signal_ff;
                  end
               end
               CMD_SET: begin
                  if (found_ff) begin
                     ram_wr_en            = 1'b1;
                     ram_wr_addr          = match_idx_ff;
                     ram_wr_data.periodic = match_periodic_ff;
                  end else if (free_found_ff) begin
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = free_idx_ff;
                     ram_wr_data.periodic  = req_ff.periodic;
                     valid_in[free_idx_ff] = 1'b1;
                  end else begin
                     rsp_in.status = STATUS_FULL;
                  end
               end
               CMD_REMOVE: begin
                  if (found_ff) begin
                     valid_in[match_idx_ff] = 1'b0;
                  end else begin
                     rsp_in.status = STATUS_NOT_FOUND;
                  end
               end
               default: begin
                  rsp_in.status = STATUS_OK;
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         issue_on_ff   <= 1'b0;
         proc_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         issue_on_ff   <= issue_on_in;
         proc_valid_ff <= proc_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      scan_idx_ff       <= scan_idx_in;
      proc_idx_ff       <= proc_idx_in;
      found_ff          <= found_in;
      match_idx_ff      <= match_idx_in;
      match_periodic_ff <= match_periodic_in;
      free_found_ff     <= free_found_in;
      free_idx_ff       <= free_idx_in;
      pend_ff           <= pend_in;
      pend_task_ff      <= pend_task_in;
      pend_signal_ff    <= pend_signal_in;
      req_ff            <= req_in;
      rsp_ff            <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // processing only happens inside the scan
   a_proc_in_scan : assert property (@(posedge clock) disable iff (reset)
      proc_valid_ff |-> (state_ff == ST_SCAN))
      else $error("slot processed outside the scan");

   // the closing cycle always produces the final result of the item
   a_done_result : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (rsp_strobe && rsp_data.last))
      else $error("missing final result after scan");

   // an expiry without last comes only from the scan
   a_early_expiry : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.kind == KIND_EXPIRY && !rsp_data.last)
         |-> $past(state_ff == ST_SCAN))
      else $error("non-final expiry outside the scan");

   // the slot RAM is never written while idle
   a_no_idle_write : assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && state_ff == ST_IDLE))
      else $error("slot write while idle");

   // a set reports full only when no slot is free
   a_full_only : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && req_ff.command == CMD_SET && !found_ff && !free_found_ff)
         |-> (valid_ff == {TIMERS{1'b1}}))
      else $error("table full reported with a free slot");

endmodule
